// ----- sv/ncev_pkg.sv -----
package ncev_pkg;

    localparam int VAL_W         = 17;
    localparam int MODE_W        = 2;
    localparam int COUNT_W       = 3;
    localparam int ADDR_W        = 3;
    localparam int TDATA_W       = 24;
    localparam int MAX_COEFS_DEF = 6;
    localparam int NUM_COEF_REGS = 6;

    localparam logic [VAL_W-1:0] Q_ONE = 17'h10000;

    // series engine
    localparam int TERM_W    = 33;
    localparam int ACC_W     = 36;
    localparam int F_W       = 18;
    localparam int STEPS     = 12;
    localparam int SIN_STEPS = 6;
    localparam int SUBSTAGES = 4;
    localparam int LANE_LAT  = STEPS * SUBSTAGES + 1;
    localparam int RECIP_SH  = 33;
    localparam int PROD_A_W  = TERM_W + VAL_W;
    localparam int PROD_C_W  = 2 * TERM_W;

    // final divide
    localparam int QUO_W = 18;

    localparam logic [ADDR_W-1:0] REG_MODE  = 3'd0;
    localparam logic [ADDR_W-1:0] REG_COUNT = 3'd1;
    localparam logic [ADDR_W-1:0] REG_COEF0 = 3'd2;

    typedef enum logic [MODE_W-1:0] {
        MODE_POLY = 2'd0,
        MODE_EXP  = 2'd1,
        MODE_SIN  = 2'd2,
        MODE_OFF  = 2'd3
    } mode_t;

    typedef struct packed {
        logic  en;
        mode_t mode;
    } lane_ctl_t;

    function automatic logic [VAL_W-1:0] sat_one(input logic [VAL_W-1:0] v);
        return (v > Q_ONE) ? Q_ONE : v;
    endfunction

endpackage

// ----- sv/ncev_series.sv -----
module ncev_series
(
    input  logic                           clk,
    input  ncev_pkg::lane_ctl_t            ctl,
    input  logic [ncev_pkg::VAL_W-1:0]     arg,
    output logic [ncev_pkg::F_W-1:0]       value
);

    localparam int TERM_W = ncev_pkg::TERM_W;
    localparam int ACC_W  = ncev_pkg::ACC_W;
    localparam int VAL_W  = ncev_pkg::VAL_W;
    localparam int STEPS  = ncev_pkg::STEPS;

    logic        [TERM_W-1:0] ta_reg [STEPS];
    logic        [VAL_W-1:0]  aa_reg [STEPS];
    logic signed [ACC_W-1:0]  sa_reg [STEPS];
    logic        [TERM_W-1:0] tb_reg [STEPS];
    logic        [VAL_W-1:0]  ab_reg [STEPS];
    logic signed [ACC_W-1:0]  sb_reg [STEPS];
    logic        [TERM_W-1:0] qc_reg [STEPS];
    logic        [TERM_W-1:0] vc_reg [STEPS];
    logic        [VAL_W-1:0]  ac_reg [STEPS];
    logic signed [ACC_W-1:0]  sc_reg [STEPS];
    logic        [TERM_W-1:0] td_reg [STEPS];
    logic        [VAL_W-1:0]  ad_reg [STEPS];
    logic signed [ACC_W-1:0]  sd_reg [STEPS];
    logic        [ncev_pkg::F_W-1:0] f_reg;
    logic        [ncev_pkg::F_W-1:0] f_next;

    logic        [TERM_W-1:0] term0;
    logic                     is_sin;
    logic signed [ACC_W-1:0]  rnd;

    assign is_sin = (ctl.mode == ncev_pkg::MODE_SIN);
    assign term0  = is_sin ? {arg, 16'h0000} : (TERM_W'(1) << 32);

    genvar s;
    generate
        for (s = 0; s < STEPS; s++)
        begin : g_step
            localparam logic [TERM_W-1:0] D_EXP = TERM_W'(s + 1);
            localparam logic [TERM_W-1:0] D_SIN = TERM_W'((2 * s + 2) * (2 * s + 3));
            localparam logic [TERM_W-1:0] R_EXP =
                TERM_W'((64'd1 << ncev_pkg::RECIP_SH) / (s + 1));
            localparam logic [TERM_W-1:0] R_SIN =
                TERM_W'((64'd1 << ncev_pkg::RECIP_SH) / ((2 * s + 2) * (2 * s + 3)));
            localparam bit DIV_ONE  = (s == 0);
            localparam bit SIN_LIVE = (s < ncev_pkg::SIN_STEPS);
            localparam bit SIN_SUB  = ((s % 2) == 0);

            logic        [TERM_W-1:0]               t_in;
            logic        [VAL_W-1:0]                a_in;
            logic signed [ACC_W-1:0]                s_in;
            logic        [ncev_pkg::PROD_A_W-1:0]   prod_a;
            logic        [ncev_pkg::PROD_A_W-1:0]   prod_b;
            logic        [ncev_pkg::PROD_C_W-1:0]   prod_c;
            logic        [TERM_W-1:0]               ta_next;
            logic        [TERM_W-1:0]               tb_next;
            logic        [TERM_W-1:0]               qc_next;
            logic        [TERM_W-1:0]               dq;
            logic        [TERM_W-1:0]               rem;
            logic        [TERM_W-1:0]               d_sel;
            logic        [TERM_W-1:0]               td_next;
            logic signed [ACC_W-1:0]                sd_next;

            if (s == 0)
            begin : g_first
                assign t_in = term0;
                assign a_in = arg;
                assign s_in = $signed(ACC_W'(term0));
            end
            else
            begin : g_chain
                assign t_in = td_reg[s-1];
                assign a_in = ad_reg[s-1];
                assign s_in = sd_reg[s-1];
            end

            always_comb
            begin
                prod_a  = ncev_pkg::PROD_A_W'(t_in) * ncev_pkg::PROD_A_W'(a_in);
                ta_next = prod_a[16 +: TERM_W];

                prod_b  = ncev_pkg::PROD_A_W'(ta_reg[s]) * ncev_pkg::PROD_A_W'(aa_reg[s]);
                tb_next = is_sin ? prod_b[16 +: TERM_W] : ta_reg[s];

                prod_c  = ncev_pkg::PROD_C_W'(tb_reg[s])
                        * ncev_pkg::PROD_C_W'(is_sin ? R_SIN : R_EXP);
                qc_next = (DIV_ONE && !is_sin) ? tb_reg[s]
                                               : prod_c[ncev_pkg::RECIP_SH +: TERM_W];

                // one correction step brings the estimate to the exact quotient
                dq      = is_sin ? TERM_W'(qc_reg[s] * D_SIN) : TERM_W'(qc_reg[s] * D_EXP);
                rem     = vc_reg[s] - dq;
                d_sel   = is_sin ? D_SIN : D_EXP;
                td_next = (rem >= d_sel) ? qc_reg[s] + TERM_W'(1) : qc_reg[s];

                if (!is_sin)
                    sd_next = sc_reg[s] + $signed(ACC_W'(td_next));
                else if (SIN_LIVE && SIN_SUB)
                    sd_next = sc_reg[s] - $signed(ACC_W'(td_next));
                else if (SIN_LIVE)
                    sd_next = sc_reg[s] + $signed(ACC_W'(td_next));
                else
                    sd_next = sc_reg[s];
            end

            always_ff @(posedge clk)
            begin
                if (ctl.en)
                begin
                    ta_reg[s] <= ta_next;
                    aa_reg[s] <= a_in;
                    sa_reg[s] <= s_in;
                    tb_reg[s] <= tb_next;
                    ab_reg[s] <= aa_reg[s];
                    sb_reg[s] <= sa_reg[s];
                    qc_reg[s] <= qc_next;
                    vc_reg[s] <= tb_reg[s];
                    ac_reg[s] <= ab_reg[s];
                    sc_reg[s] <= sb_reg[s];
                    td_reg[s] <= td_next;
                    ad_reg[s] <= ac_reg[s];
                    sd_reg[s] <= sd_next;
                end
            end
        end
    endgenerate

    always_comb
    begin
        rnd = sd_reg[STEPS-1] + $signed(ACC_W'(32768));
        case (ctl.mode)
            ncev_pkg::MODE_POLY: f_next = ncev_pkg::F_W'(ad_reg[STEPS-1]);
            ncev_pkg::MODE_EXP:  f_next = rnd[16 +: ncev_pkg::F_W];
            ncev_pkg::MODE_SIN:  f_next = sd_reg[STEPS-1][ACC_W-1] ? '0
                                                                   : rnd[16 +: ncev_pkg::F_W];
            default:             f_next = '0;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (ctl.en)
            f_reg <= f_next;
    end

    assign value = f_reg;

endmodule

// ----- sv/normalised_curve_evaluator_core.sv -----
// channel   direction  fields (low bit first)            accepted when
// s_axis    in         tdata: position[16:0]             s_axis_tvalid & s_axis_tready
// m_axis    out        tdata: curve_value[16:0]          m_axis_tvalid & m_axis_tready
//                      tuser: zero_norm
// cfg       in         cfg_addr, cfg_wdata               cfg_we
//
// One word per cycle while the output is not stalled; the pipeline runs through the 12-step series
// engines (4 stages per step) and the 18-stage bit-per-stage divider.
// Reset clears the valid bits and the configuration registers.
// The whole pipeline holds when the output register is full and not taken.
module normalised_curve_evaluator_core
#(
    parameter int MAX_COEFS = ncev_pkg::MAX_COEFS_DEF
)
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    input  logic [ncev_pkg::TDATA_W-1:0]      s_axis_tdata,   // position
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    output logic [ncev_pkg::TDATA_W-1:0]      m_axis_tdata,   // curve_value
    output logic                              m_axis_tuser,   // zero_norm
    input  logic                              cfg_we,
    input  logic [ncev_pkg::ADDR_W-1:0]       cfg_addr,
    input  logic [ncev_pkg::VAL_W-1:0]        cfg_wdata
);

    localparam int VAL_W    = ncev_pkg::VAL_W;
    localparam int F_W      = ncev_pkg::F_W;
    localparam int QUO_W    = ncev_pkg::QUO_W;
    localparam int LANE_LAT = ncev_pkg::LANE_LAT;
    localparam int LANES    = 2 * MAX_COEFS;
    localparam int SUM_W    = F_W + $clog2(MAX_COEFS);
    localparam int N_W      = SUM_W + 17;
    localparam int REM_W    = SUM_W + 1;

    logic                              en;
    ncev_pkg::mode_t                   mode_reg;
    logic [ncev_pkg::COUNT_W-1:0]      count_reg;
    logic [VAL_W-1:0]                  coef_reg [ncev_pkg::NUM_COEF_REGS];
    logic [VAL_W-1:0]                  coef_sat [MAX_COEFS];
    logic [ncev_pkg::COUNT_W-1:0]      n_eff;
    ncev_pkg::lane_ctl_t               lane_ctl;

    logic [MAX_COEFS:0]                fv_reg;
    logic [VAL_W-1:0]                  fx_reg [MAX_COEFS+1];
    logic [VAL_W-1:0]                  fp_reg [MAX_COEFS+1];
    logic [VAL_W-1:0]                  fa_reg [1:MAX_COEFS][MAX_COEFS];

    logic [VAL_W-1:0]                  lane_arg [LANES];
    logic [F_W-1:0]                    lane_f   [LANES];
    logic [LANE_LAT-1:0]               lv_reg;

    logic                              sv_reg;
    logic [SUM_W-1:0]                  num_reg;
    logic [SUM_W-1:0]                  den_reg;
    logic [SUM_W-1:0]                  num_next;
    logic [SUM_W-1:0]                  den_next;

    logic [N_W-1:0]                    nfull;
    logic [QUO_W:0]                    dvv_reg;
    logic [QUO_W-1:0]                  dn_reg   [QUO_W+1];
    logic [SUM_W-1:0]                  dd_reg   [QUO_W+1];
    logic [REM_W-1:0]                  drem_reg [QUO_W+1];
    logic [QUO_W-1:0]                  dq_reg   [QUO_W+1];
    logic                              dz_reg   [QUO_W+1];
    logic                              dovf_reg [QUO_W+1];

    logic                              out_valid_reg;
    logic [VAL_W-1:0]                  out_value_reg;
    logic                              out_zero_reg;
    logic [VAL_W-1:0]                  out_value_next;

    assign en            = !out_valid_reg || m_axis_tready;
    assign s_axis_tready = en;
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = ncev_pkg::TDATA_W'(out_value_reg);
    assign m_axis_tuser  = out_zero_reg;

    // configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  <= ncev_pkg::MODE_POLY;
            count_reg <= '0;
            for (int i = 0; i < ncev_pkg::NUM_COEF_REGS; i++)
                coef_reg[i] <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_addr)
                ncev_pkg::REG_MODE:  mode_reg  <= ncev_pkg::mode_t'(cfg_wdata[1:0]);
                ncev_pkg::REG_COUNT: count_reg <= cfg_wdata[ncev_pkg::COUNT_W-1:0];
                default:             coef_reg[cfg_addr - ncev_pkg::REG_COEF0] <= cfg_wdata;
            endcase
        end
    end

    assign n_eff = (count_reg > ncev_pkg::COUNT_W'(MAX_COEFS))
                 ? ncev_pkg::COUNT_W'(MAX_COEFS) : count_reg;

    always_comb
    begin
        for (int k = 0; k < MAX_COEFS; k++)
            coef_sat[k] = ncev_pkg::sat_one(coef_reg[k]);
    end

    // valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fv_reg        <= '0;
            lv_reg        <= '0;
            sv_reg        <= 1'b0;
            dvv_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            fv_reg        <= {fv_reg[MAX_COEFS-1:0], s_axis_tvalid};
            lv_reg        <= {lv_reg[LANE_LAT-2:0], fv_reg[MAX_COEFS]};
            sv_reg        <= lv_reg[LANE_LAT-1];
            dvv_reg       <= {dvv_reg[QUO_W-1:0], sv_reg};
            out_valid_reg <= dvv_reg[QUO_W];
        end
    end

    // powers and arguments, one degree per stage
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            fx_reg[0] <= ncev_pkg::sat_one(s_axis_tdata[VAL_W-1:0]);
            fp_reg[0] <= ncev_pkg::Q_ONE;
        end
    end

    genvar s, k, j;
    generate
        for (s = 0; s < MAX_COEFS; s++)
        begin : g_front
            logic [33:0] pa;
            logic [33:0] pp;

            assign pa = 34'(coef_sat[s]) * 34'(fp_reg[s]) + 34'd32768;
            assign pp = 34'(fp_reg[s]) * 34'(fx_reg[s]) + 34'd32768;

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    fx_reg[s+1]    <= fx_reg[s];
                    fp_reg[s+1]    <= pp[16 +: VAL_W];
                    fa_reg[s+1][s] <= pa[16 +: VAL_W];
                end
            end

            for (k = 0; k < s; k++)
            begin : g_carry
                always_ff @(posedge clk)
                begin
                    if (en)
                        fa_reg[s+1][k] <= fa_reg[s][k];
                end
            end
        end

        for (j = 0; j < LANES; j++)
        begin : g_lane
            if (j < MAX_COEFS)
            begin : g_num
                assign lane_arg[j] = fa_reg[MAX_COEFS][j];
            end
            else
            begin : g_den
                assign lane_arg[j] = coef_sat[j - MAX_COEFS];
            end

            ncev_series u_series
            (
                .clk   (clk),
                .ctl   (lane_ctl),
                .arg   (lane_arg[j]),
                .value (lane_f[j])
            );
        end
    endgenerate

    assign lane_ctl.en   = en;
    assign lane_ctl.mode = mode_reg;

    // numerator and denominator sums over the degrees in use
    always_comb
    begin
        num_next = '0;
        den_next = '0;
        for (int i = 0; i < MAX_COEFS; i++)
        begin
            if (ncev_pkg::COUNT_W'(i) < n_eff)
            begin
                num_next = num_next + SUM_W'(lane_f[i]);
                den_next = den_next + SUM_W'(lane_f[MAX_COEFS + i]);
            end
        end
    end

    assign nfull = N_W'({num_reg, 16'h0000}) + N_W'(den_reg >> 1);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            num_reg     <= num_next;
            den_reg     <= den_next;
            dn_reg[0]   <= nfull[QUO_W-1:0];
            dd_reg[0]   <= den_reg;
            drem_reg[0] <= REM_W'(nfull[N_W-1:QUO_W]);
            dq_reg[0]   <= '0;
            dz_reg[0]   <= (den_reg == '0);
            dovf_reg[0] <= (SUM_W'(nfull[N_W-1:QUO_W]) >= den_reg);
        end
    end

    // restoring divider, one quotient bit per stage
    generate
        for (s = 0; s < QUO_W; s++)
        begin : g_div
            logic [REM_W-1:0] sh;
            logic             ge;

            assign sh = {drem_reg[s][REM_W-2:0], dn_reg[s][QUO_W-1-s]};
            assign ge = (sh >= REM_W'(dd_reg[s]));

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    dn_reg[s+1]   <= dn_reg[s];
                    dd_reg[s+1]   <= dd_reg[s];
                    drem_reg[s+1] <= ge ? sh - REM_W'(dd_reg[s]) : sh;
                    dq_reg[s+1]   <= {dq_reg[s][QUO_W-2:0], ge};
                    dz_reg[s+1]   <= dz_reg[s];
                    dovf_reg[s+1] <= dovf_reg[s];
                end
            end
        end
    endgenerate

    always_comb
    begin
        if (dz_reg[QUO_W])
            out_value_next = '0;
        else if (dovf_reg[QUO_W] || (dq_reg[QUO_W] > QUO_W'(ncev_pkg::Q_ONE)))
            out_value_next = ncev_pkg::Q_ONE;
        else
            out_value_next = dq_reg[QUO_W][VAL_W-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            out_value_reg <= out_value_next;
            out_zero_reg  <= dz_reg[QUO_W];
        end
    end

    a_zero_forces_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser |-> m_axis_tdata[VAL_W-1:0] == '0)
        else $error("zero_norm with nonzero curve_value");

    a_value_saturated: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> m_axis_tdata[VAL_W-1:0] <= ncev_pkg::Q_ONE)
        else $error("curve_value above one");

    a_stall_holds_lanes: assert property (@(posedge clk) disable iff (!rst_n)
        !en |=> $stable(lv_reg) && $stable(dvv_reg))
        else $error("pipeline valid bits moved during stall");

    a_stall_holds_front: assert property (@(posedge clk) disable iff (!rst_n)
        !en |=> $stable(fv_reg) && $stable(sv_reg))
        else $error("front valid bits moved during stall");

endmodule

// ----- verif/normalised_curve_evaluator_core_test.sv -----
`timescale 1ns / 100ps

module normalised_curve_evaluator_core_test;

    localparam int MAX_COEFS_DEF  = ncev_pkg::MAX_COEFS_DEF;
    localparam int VAL_W          = ncev_pkg::VAL_W;
    localparam int TDATA_W        = ncev_pkg::TDATA_W;
    localparam int ADDR_W         = ncev_pkg::ADDR_W;
    localparam int COUNT_W        = ncev_pkg::COUNT_W;
    localparam int MODE_W         = ncev_pkg::MODE_W;
    localparam int NUM_COEF_REGS  = ncev_pkg::NUM_COEF_REGS;
    localparam int LAT            = 71 + MAX_COEFS_DEF;
    localparam int WATCHDOG_LIMIT = 20000;
    localparam int RX_HOLD_CYCLES = 400;

    typedef struct packed {
        logic [VAL_W-1:0] curve_value;
        logic             zero_norm;
    } curve_word_t;

    logic                 clk;
    logic                 rst_n;
    logic                 s_axis_tvalid;
    logic                 s_axis_tready;
    logic [TDATA_W-1:0]   s_axis_tdata;
    logic                 m_axis_tvalid;
    logic                 m_axis_tready;
    logic [TDATA_W-1:0]   m_axis_tdata;
    logic                 m_axis_tuser;
    logic                 cfg_we;
    logic [ADDR_W-1:0]    cfg_addr;
    logic [VAL_W-1:0]     cfg_wdata;

    normalised_curve_evaluator_core u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .cfg_we        (cfg_we),
        .cfg_addr      (cfg_addr),
        .cfg_wdata     (cfg_wdata)
    );

    // shadow configuration
    ncev_pkg::mode_t    mdl_mode;
    logic [COUNT_W-1:0] mdl_count;
    logic [VAL_W-1:0]   mdl_coef [NUM_COEF_REGS];

    logic [VAL_W-1:0] position_q [$];
    curve_word_t      curve_q [$];
    int               errors;
    int               words_in;
    int               words_out;
    int               zero_seen;
    int               idle_cycles;
    bit               hold_rx;
    bit               hold_tx;
    bit               driver_busy;
    bit               in_fire;

    always
    begin
        clk = 1'b1;
        #2;
        clk = 1'b0;
        #2;
    end

    function automatic logic [63:0] clip_one(input logic [63:0] v);
        return (v > 64'd65536) ? 64'd65536 : v;
    endfunction

    function automatic logic [63:0] series_exp(input logic [63:0] a);
        logic [63:0] term;
        logic [63:0] acc;
        term = 64'd1 << 32;
        acc = term;
        for (int n = 1; n <= 12; n++)
        begin
            term = ((term * a) >> 16) / n;
            acc += term;
        end
        return (acc + 64'd32768) >> 16;
    endfunction

    function automatic logic [63:0] series_sin(input logic [63:0] a);
        logic [63:0]        term;
        logic signed [63:0] acc;
        bit                 neg;
        term = a << 16;
        acc = $signed(term);
        neg = 1'b1;
        for (int n = 3; n <= 13; n += 2)
        begin
            term = ((((term * a) >> 16) * a) >> 16) / ((n - 1) * n);
            if (neg)
                acc -= $signed(term);
            else
                acc += $signed(term);
            neg = !neg;
        end
        if (acc < 0)
            acc = 0;
        return ($unsigned(acc) + 64'd32768) >> 16;
    endfunction

    function automatic curve_word_t eval_curve(input logic [VAL_W-1:0] pos);
        logic [63:0] x;
        logic [63:0] pw;
        logic [63:0] c;
        logic [63:0] a;
        logic [63:0] num;
        logic [63:0] den;
        int          cnt;
        curve_word_t r;
        x = clip_one(64'(pos));
        cnt = (mdl_count > MAX_COEFS_DEF) ? MAX_COEFS_DEF : int'(mdl_count);
        pw = 64'd65536;
        num = 0;
        den = 0;
        for (int k = 0; k < cnt; k++)
        begin
            c = clip_one(64'(mdl_coef[k]));
            a = (c * pw + 64'd32768) >> 16;
            case (mdl_mode)
                ncev_pkg::MODE_POLY:
                begin
                    num += a;
                    den += c;
                end
                ncev_pkg::MODE_EXP:
                begin
                    num += series_exp(a);
                    den += series_exp(c);
                end
                ncev_pkg::MODE_SIN:
                begin
                    num += series_sin(a);
                    den += series_sin(c);
                end
                default:
                begin
                end
            endcase
            pw = (pw * x + 64'd32768) >> 16;
        end
        if (den == 0)
        begin
            r.curve_value = '0;
            r.zero_norm = 1'b1;
        end
        else
        begin
            r.curve_value = VAL_W'(clip_one(((num << 16) + den / 2) / den));
            r.zero_norm = 1'b0;
        end
        return r;
    endfunction

    task automatic write_reg(input logic [ADDR_W-1:0] idx, input logic [VAL_W-1:0] val);
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_addr <= idx;
        cfg_wdata <= val;
        case (idx)
            ncev_pkg::REG_MODE:  mdl_mode = ncev_pkg::mode_t'(val[MODE_W-1:0]);
            ncev_pkg::REG_COUNT: mdl_count = val[COUNT_W-1:0];
            default:             mdl_coef[idx - ncev_pkg::REG_COEF0] = val;
        endcase
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic drain;
        wait (position_q.size() == 0 && !driver_busy && curve_q.size() == 0);
        repeat (LAT + 10) @(posedge clk);
    endtask

    function automatic logic [VAL_W-1:0] rand_val;
        case ($urandom_range(0, 7))
            0: return '0;
            1: return 17'h10000;
            2: return 17'h1FFFF;
            3: return VAL_W'($urandom_range(65537, 131071));
            default: return VAL_W'($urandom_range(0, 65536));
        endcase
    endfunction

    task automatic setup(input ncev_pkg::mode_t m, input int cnt, input bit rand_coefs);
        drain();
        write_reg(ncev_pkg::REG_MODE, VAL_W'(m));
        write_reg(ncev_pkg::REG_COUNT, VAL_W'(cnt));
        for (int k = 0; k < NUM_COEF_REGS; k++)
            write_reg(ncev_pkg::REG_COEF0 + ADDR_W'(k), rand_coefs ? rand_val() : 17'h10000);
    endtask

    // driver: bursts with gaps
    int burst_left;
    int gap_left;
    always @(negedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata <= '0;
            burst_left = 0;
            gap_left = 0;
            driver_busy = 1'b0;
        end
        else
        begin
            if (in_fire)
                driver_busy = 1'b0;
            if (!driver_busy)
            begin
                if (gap_left > 0)
                begin
                    gap_left--;
                    s_axis_tvalid <= 1'b0;
                end
                else if (position_q.size() > 0 && !hold_tx)
                begin
                    s_axis_tdata <= TDATA_W'(position_q.pop_front());
                    s_axis_tvalid <= 1'b1;
                    driver_busy = 1'b1;
                    if (burst_left > 0)
                        burst_left--;
                    else
                    begin
                        burst_left = $urandom_range(0, 40);
                        gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 6);
                    end
                end
                else
                    s_axis_tvalid <= 1'b0;
            end
        end
    end

    // input acceptance: predict
    always @(posedge clk)
    begin
        in_fire <= rst_n && s_axis_tvalid && s_axis_tready;
        if (rst_n && s_axis_tvalid && s_axis_tready)
        begin
            curve_q.push_back(eval_curve(s_axis_tdata[VAL_W-1:0]));
            words_in++;
        end
    end

    // receiver stall pattern
    int stall_phase;
    int rx_hold_left;
    bit rx_hold_used;
    always @(negedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_axis_tready <= 1'b0;
            stall_phase = 0;
            rx_hold_left = 0;
        end
        else
        begin
            stall_phase = (stall_phase + 1) % 300;
            if (hold_rx && !rx_hold_used)
            begin
                rx_hold_used = 1'b1;
                rx_hold_left = RX_HOLD_CYCLES;
            end
            if (rx_hold_left > 0)
            begin
                rx_hold_left--;
                m_axis_tready <= 1'b0;
            end
            else if (stall_phase < 100)
                m_axis_tready <= 1'b1;
            else if (stall_phase < 200)
                m_axis_tready <= ($urandom_range(0, 3) != 0);
            else
                m_axis_tready <= stall_phase[2] ^ stall_phase[0];
        end
    end

    // monitor
    always @(posedge clk)
    begin
        curve_word_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            words_out++;
            if (curve_q.size() == 0)
            begin
                $error("unexpected word: curve_value %0d zero_norm %0d",
                       m_axis_tdata[VAL_W-1:0], m_axis_tuser);
                errors++;
            end
            else
            begin
                want = curve_q.pop_front();
                if (m_axis_tuser) zero_seen++;
                if (m_axis_tdata[VAL_W-1:0] !== want.curve_value)
                begin
                    $error("curve_value expected %0d actual %0d",
                           want.curve_value, m_axis_tdata[VAL_W-1:0]);
                    errors++;
                end
                if (m_axis_tdata[TDATA_W-1:VAL_W] !== '0)
                begin
                    $error("tdata pad expected 0 actual %0h", m_axis_tdata[TDATA_W-1:VAL_W]);
                    errors++;
                end
                if (m_axis_tuser !== want.zero_norm)
                begin
                    $error("zero_norm expected %0d actual %0d", want.zero_norm, m_axis_tuser);
                    errors++;
                end
            end
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        if (!rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
            || (position_q.size() == 0 && curve_q.size() == 0 && !driver_busy) || hold_rx)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("normalised_curve_evaluator_core verification failed");
            $finish;
        end
    end

    initial
    begin
        logic [VAL_W-1:0] dir_pos [8];
        hold_rx = 1'b0;
        hold_tx = 1'b0;
        cfg_we = 1'b0;
        cfg_addr = '0;
        cfg_wdata = '0;
        mdl_mode = ncev_pkg::MODE_POLY;
        mdl_count = '0;
        for (int k = 0; k < NUM_COEF_REGS; k++)
            mdl_coef[k] = '0;
        rst_n = 1'b0;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        dir_pos = '{17'h0, 17'h1, 17'h8000, 17'hFFFF, 17'h10000, 17'h10001, 17'h1FFFF, 17'h4000};

        // reset config: zero count gives zero normalizer
        position_q.push_back(17'h8000);
        position_q.push_back(17'h10000);
        // directed: poly, exp and sin modes at full count, poly with unit coefficients, exp and sin with random ones
        setup(ncev_pkg::MODE_POLY, 6, 1'b0);
        foreach (dir_pos[i]) position_q.push_back(dir_pos[i]);
        setup(ncev_pkg::MODE_EXP, 6, 1'b1);
        foreach (dir_pos[i]) position_q.push_back(dir_pos[i]);
        setup(ncev_pkg::MODE_SIN, 7, 1'b1);
        for (int i = 0; i < 4; i++) position_q.push_back(dir_pos[i * 2]);
        // all-zero coefficients
        drain();
        for (int k = 0; k < NUM_COEF_REGS; k++)
            write_reg(ncev_pkg::REG_COEF0 + ADDR_W'(k), '0);
        position_q.push_back(17'h8000);
        drain();
        write_reg(ncev_pkg::REG_MODE, VAL_W'(ncev_pkg::MODE_POLY));
        position_q.push_back(17'h8000);
        drain();
        write_reg(ncev_pkg::REG_MODE, VAL_W'(ncev_pkg::MODE_OFF));
        write_reg(ncev_pkg::REG_COUNT, 17'd5);
        position_q.push_back(17'h10000);

        // random phases
        for (int ph = 0; ph < 28; ph++)
        begin
            setup(ncev_pkg::mode_t'((ph % 7 == 6) ? 3 : ph % 3), $urandom_range(0, 7), 1'b1);
            if (ph == 5)
            begin
                hold_rx = 1'b1;
                for (int i = 0; i < 120; i++)
                    position_q.push_back(rand_val());
                wait (rx_hold_used && rx_hold_left == 0);
                hold_rx = 1'b0;
            end
            else
                for (int i = 0; i < 48; i++)
                    position_q.push_back(rand_val());
            if (ph == 10)
            begin
                wait (position_q.size() < 24);
                hold_tx = 1'b1;
                wait (curve_q.size() == 0 && !driver_busy);
                hold_tx = 1'b0;
            end
        end

        drain();
        $display("%0d positions sent, %0d values checked, %0d zero normalizer results",
                 words_in, words_out, zero_seen);
        if (errors == 0)
            $display("normalised_curve_evaluator_core verification clean");
        else
            $display("normalised_curve_evaluator_core verification failed");
        $finish;
    end

endmodule

// ----- filelist.f -----
sv/ncev_pkg.sv
sv/ncev_series.sv
sv/normalised_curve_evaluator_core.sv
verif/normalised_curve_evaluator_core_test.sv
